/* rtl/core/urb_pkg.sv */
// Shared types and constants for the UART ring-buffer unit.
// Used by urb_ring and uart_rx_tx_ring_buffers_unit; depends on nothing.
package urb_pkg;

  typedef enum logic [1:0] {
    CMD_RX_BYTE  = 2'd0,
    CMD_HOST_RD  = 2'd1,
    CMD_HOST_WR  = 2'd2,
    CMD_TX_READY = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FRAME   = 3'd1,
    ST_OVERRUN = 3'd2,
    ST_PARITY  = 3'd3,
    ST_NODATA  = 3'd4
  } status_t;

  // Line flag bit positions
  localparam int FLAG_FRAME   = 0;
  localparam int FLAG_OVERRUN = 1;
  localparam int FLAG_PARITY  = 2;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ring_stat_t;

  // Priority decode: frame error, then overrun, then parity
  function automatic status_t decode_flags(input logic [2:0] flags);
    status_t st;
    if (flags[FLAG_FRAME]) begin
      st = ST_FRAME;
    end else if (flags[FLAG_OVERRUN]) begin
      st = ST_OVERRUN;
    end else if (flags[FLAG_PARITY]) begin
      st = ST_PARITY;
    end else begin
      st = ST_OK;
    end
    return st;
  endfunction

endpackage

/* rtl/core/urb_ring.sv */
// Byte ring with one slot kept empty: head/tail pointers, storage array and
// registered pop data. Depends on urb_pkg.
module urb_ring #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  urb_pkg::ring_req_t req,
  input  logic [7:0]         wdata,
  output urb_pkg::ring_stat_t stat,
  output logic [7:0]         rdata,
  output logic [3:0]         cnt_nxt
);
  import urb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = (PW + 1 > 4) ? PW + 1 : 4;
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [7:0]    store_r [DEPTH];
  logic [PW-1:0] head_r, tail_r;
  logic [PW-1:0] head_inc, tail_inc;
  logic [PW-1:0] head_nxt, tail_nxt;
  logic [CW-1:0] diff;

  always_comb begin
    head_inc   = (head_r == LAST) ? '0 : head_r + 1'b1;
    tail_inc   = (tail_r == LAST) ? '0 : tail_r + 1'b1;
    stat.full  = (head_inc == tail_r);
    stat.empty = (head_r == tail_r);
    head_nxt   = req.push ? head_inc : head_r;
    tail_nxt   = req.pop ? tail_inc : tail_r;
    // fill after this request, modulo the depth
    diff = CW'(head_nxt) + DEPTH_C - CW'(tail_nxt);
    if (diff >= DEPTH_C) begin
      diff = diff - DEPTH_C;
    end
    cnt_nxt = diff[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      store_r[head_inc] <= wdata;
    end
    if (req.pop) begin
      rdata <= store_r[tail_inc];
    end
  end

endmodule

/* rtl/core/uart_rx_tx_ring_buffers_unit.sv */
// UART buffer engine top level: request decode, status and interrupt-enable
// state, pipeline and output registers. Depends on urb_pkg and urb_ring.
//
// Usage: each request on the in_ channel carries a command (byte received
// from the line, host read, host write, transmitter ready), a data byte and
// the line flags. Every request yields exactly one result on the out_ channel
// with the popped rx byte, status, any tx byte handed out, the write accept
// flag, the tx interrupt enable and the rx fill count after the request.
// Path: an accepted request is held in the middle stage, then in the output registers.
// Throughput: one request per cycle while in_stall is low; ring pointers and
// status update at the accepting edge, and the ring storage read lands in a
// register that feeds the result stage.
// Reset (rst_n low, synchronous): both rings empty, status ok, interrupt
// enable clear, no result pending. Ring storage is not cleared.
// Stall: while out_stall holds a result, one more request can sit in the
// middle stage; after that in_stall rises until the result is taken.
module uart_rx_tx_ring_buffers_unit #(
  parameter int RX_DEPTH = 16,
  parameter int TX_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_data_byte,
  input  logic [2:0] in_line_flags,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_byte,
  output logic [2:0] out_status,
  output logic       out_tx_out_valid,
  output logic [7:0] out_tx_out_byte,
  output logic       out_tx_accepted,
  output logic       out_tx_irq_enable,
  output logic [3:0] out_rx_count
);
  import urb_pkg::*;

  cmd_t       cmd;
  logic       accept;
  logic       out_load;
  logic       s1_free;
  ring_req_t  rx_req, tx_req;
  ring_stat_t rx_stat, tx_stat;
  logic [7:0] rx_rdata, tx_rdata;
  logic [3:0] rx_cnt_nxt;

  status_t    last_status_r, last_status_nxt;
  logic       irq_en_r, irq_en_nxt;
  status_t    res_status;

  logic       s1_v_r;
  status_t    s1_status_r;
  logic       s1_rdv_r;
  logic       s1_txv_r;
  logic       s1_acc_r;
  logic       s1_irq_r;
  logic [3:0] s1_cnt_r;

  logic       out_valid_r;
  logic [7:0] out_read_byte_r;
  logic [2:0] out_status_r;
  logic       out_txv_r;
  logic [7:0] out_txb_r;
  logic       out_acc_r;
  logic       out_irq_r;
  logic [3:0] out_cnt_r;

  // handshake: hold the middle stage while the output register is stuck
  assign out_load = s1_v_r && (!out_valid_r || !out_stall);
  assign s1_free  = !s1_v_r || out_load;
  assign in_stall = !s1_free;
  assign accept   = in_valid && s1_free;
  assign cmd      = cmd_t'(in_cmd);

  always_comb begin
    rx_req          = '0;
    tx_req          = '0;
    last_status_nxt = last_status_r;
    irq_en_nxt      = irq_en_r;
    res_status      = last_status_r;
    case (cmd)
      CMD_RX_BYTE: begin
        rx_req.push     = accept && !rx_stat.full;
        // drop the byte and flag overrun when the ring is full
        last_status_nxt = rx_stat.full ? ST_OVERRUN : decode_flags(in_line_flags);
        res_status      = last_status_nxt;
      end
      CMD_HOST_RD: begin
        rx_req.pop = accept && !rx_stat.empty;
        res_status = rx_stat.empty ? ST_NODATA : last_status_r;
      end
      CMD_HOST_WR: begin
        tx_req.push = accept && !tx_stat.full;
        irq_en_nxt  = 1'b1;
      end
      CMD_TX_READY: begin
        tx_req.pop = accept && !tx_stat.empty;
        if (tx_stat.empty) begin
          irq_en_nxt = 1'b0;
        end
      end
      default: begin
        res_status = last_status_r;
      end
    endcase
  end

  urb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (rx_req),
    .wdata   (in_data_byte),
    .stat    (rx_stat),
    .rdata   (rx_rdata),
    .cnt_nxt (rx_cnt_nxt)
  );

  urb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (tx_req),
    .wdata   (in_data_byte),
    .stat    (tx_stat),
    .rdata   (tx_rdata),
    .cnt_nxt ()
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_status_r <= ST_OK;
      irq_en_r      <= 1'b0;
      s1_v_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        last_status_r <= last_status_nxt;
        irq_en_r      <= irq_en_nxt;
        s1_v_r        <= 1'b1;
      end else if (out_load) begin
        s1_v_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= res_status;
      s1_rdv_r    <= rx_req.pop;
      s1_txv_r    <= tx_req.pop;
      s1_acc_r    <= tx_req.push;
      s1_irq_r    <= irq_en_nxt;
      s1_cnt_r    <= rx_cnt_nxt;
    end
    if (out_load) begin
      out_read_byte_r <= s1_rdv_r ? rx_rdata : 8'd0;
      out_status_r    <= s1_status_r;
      out_txv_r       <= s1_txv_r;
      out_txb_r       <= s1_txv_r ? tx_rdata : 8'd0;
      out_acc_r       <= s1_acc_r;
      out_irq_r       <= s1_irq_r;
      out_cnt_r       <= s1_cnt_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_byte     = out_read_byte_r;
  assign out_status        = out_status_r;
  assign out_tx_out_valid  = out_txv_r;
  assign out_tx_out_byte   = out_txb_r;
  assign out_tx_accepted   = out_acc_r;
  assign out_tx_irq_enable = out_irq_r;
  assign out_rx_count      = out_cnt_r;

endmodule
